// File: design/gfde_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the GIF frame delay extractor.
// No dependencies; used by gif_frame_delay_extractor, gfde_stream_checker and gif_frame_delay_extractor_tb.
package gfde_pkg;

    typedef enum logic [18:0] {
        PH_HEADER       = 19'd1,
        PH_GTABLE       = 19'd2,
        PH_BLOCK        = 19'd4,
        PH_LABEL        = 19'd8,
        PH_GCE          = 19'd16,
        PH_APP_LEN      = 19'd32,
        PH_APP_ID       = 19'd64,
        PH_APP_VLEN     = 19'd128,
        PH_APP_VAL      = 19'd256,
        PH_APP_TERM     = 19'd512,
        PH_EXT_SUB_LEN  = 19'd1024,
        PH_EXT_SUB_DATA = 19'd2048,
        PH_IMG_DESC     = 19'd4096,
        PH_IMG_LTABLE   = 19'd8192,
        PH_IMG_LZW      = 19'd16384,
        PH_IMG_SUB_LEN  = 19'd32768,
        PH_IMG_SUB_DATA = 19'd65536,
        PH_FAIL_FMT     = 19'd131072,
        PH_FAIL_LIM     = 19'd262144
    } phase_t;

    localparam logic [7:0] GIF_TRAILER    = 8'h3B;
    localparam logic [7:0] GIF_EXT_INTRO  = 8'h21;
    localparam logic [7:0] GIF_IMG_INTRO  = 8'h2C;
    localparam logic [7:0] LBL_GCE        = 8'hF9;
    localparam logic [7:0] LBL_APP        = 8'hFF;
    localparam logic [7:0] LBL_PLAIN_TEXT = 8'h01;
    localparam logic [7:0] TABLE_FLAG     = 8'h80;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_FMT = 2'd1;
    localparam logic [1:0] ST_LIM = 2'd2;

    localparam logic [16:0] LOOP_NONE = 17'h1FFFF;

    localparam logic [2:0] REG_EXPECTED_FRAMES = 3'd0;
    localparam logic [2:0] REG_MAX_DURATION    = 3'd1;
    localparam logic [2:0] REG_DEFAULT_DELAY   = 3'd2;
    localparam logic [2:0] REG_MIN_DELAY       = 3'd3;
    localparam logic [2:0] REG_MAX_BLOCKS      = 3'd4;

    localparam logic [7:0] LOOP_ID_A [11] = '{8'h4e, 8'h45, 8'h54, 8'h53, 8'h43, 8'h41,
                                             8'h50, 8'h45, 8'h32, 8'h2e, 8'h30};
    localparam logic [7:0] LOOP_ID_B [11] = '{8'h41, 8'h4e, 8'h49, 8'h4d, 8'h45, 8'h58,
                                             8'h54, 8'h53, 8'h31, 8'h2e, 8'h30};

    // Color table size in bytes: 3 * 2^(size field + 1)
    function automatic logic [9:0] table_size(input logic [7:0] packed_b);
        logic [3:0] sh;
        sh = {1'b0, packed_b[2:0]} + 4'd1;
        return 10'd3 << sh;
    endfunction

endpackage

// File: design/gif_frame_delay_extractor.sv
`timescale 1ns / 1ps
// GIF frame delay extractor: walks the GIF block structure one byte per beat.
// Results are registered: each goes to the result register, or to the skid while that one is full.
// Throughput: one byte per cycle (skid empty); the parser is a single registered state update.
// A two-deep output (result register plus skid) keeps s_tready high while one result waits.
// Reset (aresetn low, synchronous): parser to header phase, outputs empty, registers to defaults.
// Depends on gfde_pkg and gfde_ms_to_cs.
module gif_frame_delay_extractor #(
    parameter int DURATION_WIDTH = 40
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] frame_index, [31:16] delay_cs, [33:32] status, [50:34] loop_count, rest zero
    output logic [55:0] m_tdata,
    output logic        m_tuser,   // kind: 0 frame delay, 1 end-of-file status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int DW = DURATION_WIDTH;
    localparam logic [DW-1:0] DUR_MAX = {DW{1'b1}};

    // ---------------- configuration registers ----------------
    logic [15:0] expected_frames_reg;
    logic [30:0] max_duration_reg;
    logic [19:0] default_delay_reg;
    logic [19:0] min_delay_reg;
    logic [19:0] max_blocks_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_frames_reg <= 16'd1;
            max_duration_reg    <= 31'd0;
            default_delay_reg   <= 20'd100;
            min_delay_reg       <= 20'd20;
            max_blocks_reg      <= 20'd65536;
        end else if (cfg_wr) begin
            case (cfg_idx)
                gfde_pkg::REG_EXPECTED_FRAMES: expected_frames_reg <= pwdata[15:0];
                gfde_pkg::REG_MAX_DURATION:    max_duration_reg    <= pwdata[30:0];
                gfde_pkg::REG_DEFAULT_DELAY:   default_delay_reg   <= pwdata[19:0];
                gfde_pkg::REG_MIN_DELAY:       min_delay_reg       <= pwdata[19:0];
                gfde_pkg::REG_MAX_BLOCKS:      max_blocks_reg      <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            gfde_pkg::REG_EXPECTED_FRAMES: prdata = {16'd0, expected_frames_reg};
            gfde_pkg::REG_MAX_DURATION:    prdata = {1'b0, max_duration_reg};
            gfde_pkg::REG_DEFAULT_DELAY:   prdata = {12'd0, default_delay_reg};
            gfde_pkg::REG_MIN_DELAY:       prdata = {12'd0, min_delay_reg};
            gfde_pkg::REG_MAX_BLOCKS:      prdata = {12'd0, max_blocks_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    // Registered centisecond forms of the delay registers; they change in the cycle after those do.
    logic [15:0] default_cs_reg;
    logic [15:0] min_cs_reg;

    gfde_ms_to_cs u_default_cs (.aclk(aclk), .ms(default_delay_reg), .cs_reg(default_cs_reg));
    gfde_ms_to_cs u_min_cs     (.aclk(aclk), .ms(min_delay_reg),     .cs_reg(min_cs_reg));

    // ---------------- parser state ----------------
    gfde_pkg::phase_t phase_reg, phase_next;
    logic [9:0]    pos_reg, pos_next;
    logic [9:0]    skip_reg, skip_next;
    logic [19:0]   blocks_reg, blocks_next;
    logic [15:0]   pend_delay_reg, pend_delay_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [16:0]   loop_reg, loop_next;
    logic          loop_seen_reg, loop_seen_next;
    logic [15:0]   frames_reg, frames_next;
    logic [DW-1:0] total_reg, total_next;
    logic [1:0]    idm_reg, idm_next;
    logic [7:0]    saved_reg, saved_next;
    logic          fwl_reg, fwl_next;

    logic          s_fire;
    logic [7:0]    b;
    logic          last;
    logic          blk_ok;
    logic          frame_done;
    logic          trailer_ok;
    logic [9:0]    skip_dec;
    logic [19:0]   raw_x10;
    logic [15:0]   raw;
    logic [15:0]   dl;
    logic [19:0]   d10;
    logic [DW:0]   dur_sum;
    logic [3:0]    id_idx;

    // result of this beat
    logic          res_valid;
    logic          res_kind;
    logic [55:0]   res_data;
    logic [1:0]    res_status;

    assign b        = s_tdata;
    assign last     = s_tlast;
    assign blk_ok   = blocks_reg < max_blocks_reg;
    assign skip_dec = skip_reg - 10'd1;
    assign raw      = {b, saved_reg};
    assign raw_x10  = {1'b0, raw, 3'b000} + {3'b000, raw, 1'b0};
    assign dl       = pend_valid_reg ? pend_delay_reg : default_cs_reg;
    assign d10      = {1'b0, dl, 3'b000} + {3'b000, dl, 1'b0};
    assign dur_sum  = {1'b0, total_reg} + {{(DW-19){1'b0}}, d10};
    assign id_idx   = pos_reg[3:0];

    always_comb begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        skip_next       = skip_reg;
        blocks_next     = blocks_reg;
        pend_delay_next = pend_delay_reg;
        pend_valid_next = pend_valid_reg;
        loop_next       = loop_reg;
        loop_seen_next  = loop_seen_reg;
        frames_next     = frames_reg;
        total_next      = total_reg;
        idm_next        = idm_reg;
        saved_next      = saved_reg;
        fwl_next        = fwl_reg;
        frame_done      = 1'b0;
        trailer_ok      = 1'b0;

        if (!fwl_reg) begin
            case (phase_reg)
                gfde_pkg::PH_HEADER: begin
                    if (pos_reg == 10'd10) saved_next = b;
                    if (pos_reg == 10'd12) begin
                        pos_next = 10'd0;
                        if (saved_reg[7]) begin
                            skip_next  = gfde_pkg::table_size(saved_reg);
                            phase_next = gfde_pkg::PH_GTABLE;
                        end else begin
                            phase_next = gfde_pkg::PH_BLOCK;
                        end
                    end else begin
                        pos_next = pos_reg + 10'd1;
                    end
                end
                gfde_pkg::PH_GTABLE, gfde_pkg::PH_IMG_LTABLE: begin
                    skip_next = skip_dec;
                    if (skip_dec == 10'd0)
                        phase_next = (phase_reg == gfde_pkg::PH_GTABLE) ?
                                     gfde_pkg::PH_BLOCK : gfde_pkg::PH_IMG_LZW;
                end
                gfde_pkg::PH_BLOCK: begin
                    if (!blk_ok) begin
                        phase_next = gfde_pkg::PH_FAIL_LIM; fwl_next = 1'b1;
                    end else begin
                        blocks_next = blocks_reg + 20'd1;
                        if (b == gfde_pkg::GIF_TRAILER) begin
                            if (!last || pend_valid_reg || expected_frames_reg == 16'd0 ||
                                frames_reg != expected_frames_reg) begin
                                phase_next = gfde_pkg::PH_FAIL_FMT; fwl_next = 1'b1;
                            end else begin
                                trailer_ok = 1'b1;
                            end
                        end else if (b == gfde_pkg::GIF_EXT_INTRO) begin
                            phase_next = gfde_pkg::PH_LABEL;
                        end else if (b != gfde_pkg::GIF_IMG_INTRO ||
                                     frames_reg >= expected_frames_reg) begin
                            phase_next = gfde_pkg::PH_FAIL_FMT; fwl_next = 1'b1;
                        end else begin
                            pos_next   = 10'd0;
                            phase_next = gfde_pkg::PH_IMG_DESC;
                        end
                    end
                end
                gfde_pkg::PH_LABEL: begin
                    if (b == gfde_pkg::LBL_GCE) begin
                        if (pend_valid_reg) begin
                            phase_next = gfde_pkg::PH_FAIL_FMT; fwl_next = 1'b1;
                        end else begin
                            pos_next   = 10'd0;
                            phase_next = gfde_pkg::PH_GCE;
                        end
                    end else if (b == gfde_pkg::LBL_APP) begin
                        phase_next = gfde_pkg::PH_APP_LEN;
                    end else begin
                        // plain text cancels a pending graphics control delay
                        if (b == gfde_pkg::LBL_PLAIN_TEXT) pend_valid_next = 1'b0;
                        phase_next = gfde_pkg::PH_EXT_SUB_LEN;
                    end
                end
                gfde_pkg::PH_GCE: begin
                    if (pos_reg == 10'd0 && b != 8'd4) begin
                        phase_next = gfde_pkg::PH_FAIL_FMT; fwl_next = 1'b1;
                    end else if (pos_reg == 10'd5) begin
                        if (b != 8'd0) begin
                            phase_next = gfde_pkg::PH_FAIL_FMT; fwl_next = 1'b1;
                        end else begin
                            pend_valid_next = 1'b1;
                            pos_next        = 10'd0;
                            phase_next      = gfde_pkg::PH_BLOCK;
                        end
                    end else begin
                        if (pos_reg == 10'd2) saved_next = b;
                        if (pos_reg == 10'd3) begin
                            if (raw == 16'd0)             pend_delay_next = default_cs_reg;
                            else if (raw_x10 < min_delay_reg) pend_delay_next = min_cs_reg;
                            else                          pend_delay_next = raw;
                        end
                        pos_next = pos_reg + 10'd1;
                    end
                end
                gfde_pkg::PH_APP_LEN: begin
                    if (!blk_ok) begin
                        phase_next = gfde_pkg::PH_FAIL_LIM; fwl_next = 1'b1;
                    end else begin
                        blocks_next = blocks_reg + 20'd1;
                        if (b == 8'd0) begin
                            phase_next = gfde_pkg::PH_BLOCK;
                        end else begin
                            idm_next   = (b == 8'd11) ? 2'b11 : 2'b00;
                            skip_next  = {2'b00, b};
                            pos_next   = 10'd0;
                            phase_next = gfde_pkg::PH_APP_ID;
                        end
                    end
                end
                gfde_pkg::PH_APP_ID: begin
                    if (pos_reg < 10'd11) begin
                        if (b != gfde_pkg::LOOP_ID_A[id_idx]) idm_next[0] = 1'b0;
                        if (b != gfde_pkg::LOOP_ID_B[id_idx]) idm_next[1] = 1'b0;
                    end
                    pos_next  = pos_reg + 10'd1;
                    skip_next = skip_dec;
                    if (skip_dec == 10'd0) begin
                        pos_next = 10'd0;
                        if (idm_next != 2'b00) begin
                            // a second looping block is a format error
                            if (loop_seen_reg) begin
                                phase_next = gfde_pkg::PH_FAIL_FMT; fwl_next = 1'b1;
                            end else begin
                                phase_next = gfde_pkg::PH_APP_VLEN;
                            end
                        end else begin
                            phase_next = gfde_pkg::PH_EXT_SUB_LEN;
                        end
                    end
                end
                gfde_pkg::PH_APP_VLEN: begin
                    if (!blk_ok) begin
                        phase_next = gfde_pkg::PH_FAIL_LIM; fwl_next = 1'b1;
                    end else begin
                        blocks_next = blocks_reg + 20'd1;
                        if (b != 8'd3) begin
                            phase_next = gfde_pkg::PH_FAIL_FMT; fwl_next = 1'b1;
                        end else begin
                            pos_next   = 10'd0;
                            phase_next = gfde_pkg::PH_APP_VAL;
                        end
                    end
                end
                gfde_pkg::PH_APP_VAL: begin
                    if (pos_reg == 10'd0) begin
                        if (b != 8'd1) begin
                            phase_next = gfde_pkg::PH_FAIL_FMT; fwl_next = 1'b1;
                        end else begin
                            pos_next = pos_reg + 10'd1;
                        end
                    end else if (pos_reg == 10'd1) begin
                        saved_next = b;
                        pos_next   = pos_reg + 10'd1;
                    end else begin
                        loop_next  = {1'b0, b, saved_reg};
                        pos_next   = 10'd0;
                        phase_next = gfde_pkg::PH_APP_TERM;
                    end
                end
                gfde_pkg::PH_APP_TERM: begin
                    if (!blk_ok) begin
                        phase_next = gfde_pkg::PH_FAIL_LIM; fwl_next = 1'b1;
                    end else begin
                        blocks_next = blocks_reg + 20'd1;
                        if (b != 8'd0) begin
                            phase_next = gfde_pkg::PH_FAIL_FMT; fwl_next = 1'b1;
                        end else begin
                            loop_seen_next = 1'b1;
                            phase_next     = gfde_pkg::PH_BLOCK;
                        end
                    end
                end
                gfde_pkg::PH_EXT_SUB_LEN, gfde_pkg::PH_IMG_SUB_LEN: begin
                    if (!blk_ok) begin
                        phase_next = gfde_pkg::PH_FAIL_LIM; fwl_next = 1'b1;
                    end else begin
                        blocks_next = blocks_reg + 20'd1;
                        if (b != 8'd0) begin
                            skip_next  = {2'b00, b};
                            phase_next = (phase_reg == gfde_pkg::PH_EXT_SUB_LEN) ?
                                         gfde_pkg::PH_EXT_SUB_DATA : gfde_pkg::PH_IMG_SUB_DATA;
                        end else if (phase_reg == gfde_pkg::PH_EXT_SUB_LEN) begin
                            phase_next = gfde_pkg::PH_BLOCK;
                        end else if (dur_sum[DW]) begin
                            // total would wrap past the duration counter
                            phase_next = gfde_pkg::PH_FAIL_LIM; fwl_next = 1'b1;
                        end else if (max_duration_reg != 31'd0 &&
                                     dur_sum[DW-1:0] > {{(DW-31){1'b0}}, max_duration_reg}) begin
                            phase_next = gfde_pkg::PH_FAIL_LIM; fwl_next = 1'b1;
                        end else begin
                            total_next      = dur_sum[DW-1:0];
                            frame_done      = 1'b1;
                            pend_valid_next = 1'b0;
                            phase_next      = gfde_pkg::PH_BLOCK;
                        end
                    end
                end
                gfde_pkg::PH_EXT_SUB_DATA, gfde_pkg::PH_IMG_SUB_DATA: begin
                    skip_next = skip_dec;
                    if (skip_dec == 10'd0)
                        phase_next = (phase_reg == gfde_pkg::PH_EXT_SUB_DATA) ?
                                     gfde_pkg::PH_EXT_SUB_LEN : gfde_pkg::PH_IMG_SUB_LEN;
                end
                gfde_pkg::PH_IMG_DESC: begin
                    if (pos_reg == 10'd8) begin
                        saved_next = b;
                        pos_next   = 10'd0;
                        if (b[7]) begin
                            skip_next  = gfde_pkg::table_size(b);
                            phase_next = gfde_pkg::PH_IMG_LTABLE;
                        end else begin
                            phase_next = gfde_pkg::PH_IMG_LZW;
                        end
                    end else begin
                        pos_next = pos_reg + 10'd1;
                    end
                end
                gfde_pkg::PH_IMG_LZW: begin
                    if (b < 8'd2 || b > 8'd8) begin
                        phase_next = gfde_pkg::PH_FAIL_FMT; fwl_next = 1'b1;
                    end else begin
                        phase_next = gfde_pkg::PH_IMG_SUB_LEN;
                    end
                end
                default: begin
                    phase_next = gfde_pkg::PH_FAIL_FMT; fwl_next = 1'b1;
                end
            endcase
        end

        // Build the result of this beat.
        res_valid  = 1'b0;
        res_kind   = 1'b0;
        res_status = gfde_pkg::ST_OK;
        res_data   = 56'd0;
        if (last) begin
            res_valid = 1'b1;
            res_kind  = 1'b1;
            if (fwl_next)
                res_status = (phase_next == gfde_pkg::PH_FAIL_LIM) ?
                             gfde_pkg::ST_LIM : gfde_pkg::ST_FMT;
            else
                res_status = trailer_ok ? gfde_pkg::ST_OK : gfde_pkg::ST_FMT;
            res_data = {5'd0,
                        (res_status == gfde_pkg::ST_OK) ? loop_next : gfde_pkg::LOOP_NONE,
                        res_status, 16'd0, 16'd0};
            // file done: return the parser to its reset state
            phase_next      = gfde_pkg::PH_HEADER;
            pos_next        = 10'd0;
            skip_next       = 10'd0;
            blocks_next     = 20'd0;
            pend_delay_next = 16'd0;
            pend_valid_next = 1'b0;
            loop_next       = gfde_pkg::LOOP_NONE;
            loop_seen_next  = 1'b0;
            frames_next     = 16'd0;
            total_next      = '0;
            idm_next        = 2'b11;
            saved_next      = 8'd0;
            fwl_next        = 1'b0;
        end else if (frame_done) begin
            res_valid   = 1'b1;
            res_data    = {5'd0, gfde_pkg::LOOP_NONE, gfde_pkg::ST_OK, dl, frames_reg};
            frames_next = frames_reg + 16'd1;
        end
    end

    // ---------------- output register and skid ----------------
    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [55:0] out_data_reg;
    logic        skid_valid_reg;
    logic        skid_kind_reg;
    logic [55:0] skid_data_reg;
    logic        push;
    logic        pop;

    assign s_tready = ~skid_valid_reg;
    assign s_fire   = s_tvalid & s_tready;
    assign push     = s_fire & res_valid;
    assign pop      = out_valid_reg & m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // input is held off; drain the skid into the result register
            if (pop) begin
                out_kind_reg   <= skid_kind_reg;
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= res_kind;
                out_data_reg  <= res_data;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_kind_reg  <= res_kind;
                skid_data_reg  <= res_data;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Advance the parser on every accepted byte beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= gfde_pkg::PH_HEADER;
            pos_reg        <= 10'd0;
            skip_reg       <= 10'd0;
            blocks_reg     <= 20'd0;
            pend_delay_reg <= 16'd0;
            pend_valid_reg <= 1'b0;
            loop_reg       <= gfde_pkg::LOOP_NONE;
            loop_seen_reg  <= 1'b0;
            frames_reg     <= 16'd0;
            total_reg      <= '0;
            idm_reg        <= 2'b11;
            saved_reg      <= 8'd0;
            fwl_reg        <= 1'b0;
        end else if (s_fire) begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            skip_reg       <= skip_next;
            blocks_reg     <= blocks_next;
            pend_delay_reg <= pend_delay_next;
            pend_valid_reg <= pend_valid_next;
            loop_reg       <= loop_next;
            loop_seen_reg  <= loop_seen_next;
            frames_reg     <= frames_next;
            total_reg      <= total_next;
            idm_reg        <= idm_next;
            saved_reg      <= saved_next;
            fwl_reg        <= fwl_next;
        end
    end

    // ---------------- assertions ----------------
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg) else $error("skid full with empty result register");

    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg)) else $error("parser phase not one-hot");

    a_fail_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        fwl_reg |-> (phase_reg == gfde_pkg::PH_FAIL_FMT || phase_reg == gfde_pkg::PH_FAIL_LIM))
        else $error("failure flag outside a failure phase");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (phase_reg == gfde_pkg::PH_HEADER && !fwl_reg))
        else $error("parser not returned to header after final byte");
endmodule

// File: design/gfde_ms_to_cs.sv
`timescale 1ns / 1ps
// Millisecond to centisecond conversion, saturating at 16 bits, registered.
// Depends on nothing but the clock.
module gfde_ms_to_cs (
    input  logic        aclk,
    input  logic [19:0] ms,
    output logic [15:0] cs_reg
);
    logic [39:0] prod;
    logic [16:0] quot;
    logic [15:0] cs_next;

    // divide by 10 through the reciprocal ceil(2^23/10), exact below 2^22
    assign prod    = {20'd0, ms} * 40'd838861;
    assign quot    = prod[39:23];
    assign cs_next = quot[16] ? 16'hFFFF : quot[15:0];

    always_ff @(posedge aclk) begin
        cs_reg <= cs_next;
    end
endmodule

// File: verif/gfde_stream_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the GIF frame delay extractor: mirrors the register writes,
// predicts every result beat from the byte beats and compares. Depends on gfde_pkg.
module gfde_stream_checker
    import gfde_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          outstanding
);

    localparam logic [63:0] DUR_MAX = (64'd1 << 40) - 64'd1;

    typedef struct packed {
        logic        kind;
        logic [15:0] frame_index;
        logic [15:0] delay_cs;
        logic [1:0]  status;
        logic [16:0] loop_count;
    } delay_result_t;

    delay_result_t expected_results[$];

    // register mirror
    logic [15:0] cfg_frames;
    logic [30:0] cfg_max_dur;
    logic [19:0] cfg_default;
    logic [19:0] cfg_min;
    logic [19:0] cfg_max_blocks;

    // parser mirror
    phase_t      phase;
    logic [9:0]  pos;
    logic [9:0]  skip;
    logic [19:0] blocks;
    logic [15:0] pend_delay;
    logic        pend_valid;
    logic [16:0] loop_val;
    logic        loop_seen;
    logic [15:0] frames;
    logic [63:0] total_ms;
    logic [1:0]  id_flags;
    logic [7:0]  saved;
    logic        waiting_last;

    assign outstanding = expected_results.size();

    function automatic logic [15:0] cs_of(input logic [19:0] ms);
        logic [19:0] q;
        q = ms / 10;
        return (q > 20'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic logic [9:0] color_table_bytes(input logic [7:0] pk);
        return 10'(3 << (pk[2:0] + 1));
    endfunction

    function automatic void clear_parser();
        phase = PH_HEADER; pos = 0; skip = 0; blocks = 0; pend_delay = 0;
        pend_valid = 0; loop_val = LOOP_NONE; loop_seen = 0; frames = 0;
        total_ms = 0; id_flags = 2'b11; saved = 0; waiting_last = 0;
    endfunction

    function automatic void abort_parse(input logic [1:0] code);
        phase = (code == ST_LIM) ? PH_FAIL_LIM : PH_FAIL_FMT;
        waiting_last = 1;
    endfunction

    function automatic bit count_block();
        if (blocks >= cfg_max_blocks) begin
            abort_parse(ST_LIM);
            return 0;
        end
        blocks = blocks + 1;
        return 1;
    endfunction

    // 0: nothing, 1: frame completed (delay in d), 2: trailer accepted
    function automatic int parse_byte(input logic [7:0] b, input bit last,
                                      output logic [15:0] d);
        logic [15:0] raw;
        logic [15:0] dl;
        logic [63:0] d10;
        int r;
        r = 0;
        d = 0;
        case (phase)
            PH_HEADER: begin
                if (pos == 10) saved = b;
                if (pos == 12) begin
                    pos = 0;
                    if (saved[7]) begin
                        skip = color_table_bytes(saved);
                        phase = PH_GTABLE;
                    end else phase = PH_BLOCK;
                end else pos++;
            end
            PH_GTABLE, PH_IMG_LTABLE: begin
                skip = skip - 1;
                if (skip == 0) phase = (phase == PH_GTABLE) ? PH_BLOCK : PH_IMG_LZW;
            end
            PH_BLOCK: begin
                if (count_block()) begin
                    if (b == GIF_TRAILER) begin
                        if (!last || pend_valid || cfg_frames == 0 || frames != cfg_frames)
                            abort_parse(ST_FMT);
                        else r = 2;
                    end else if (b == GIF_EXT_INTRO) phase = PH_LABEL;
                    else if (b != GIF_IMG_INTRO || frames >= cfg_frames) abort_parse(ST_FMT);
                    else begin
                        pos = 0;
                        phase = PH_IMG_DESC;
                    end
                end
            end
            PH_LABEL: begin
                if (b == LBL_GCE) begin
                    if (pend_valid) abort_parse(ST_FMT);
                    else begin
                        pos = 0;
                        phase = PH_GCE;
                    end
                end else if (b == LBL_APP) phase = PH_APP_LEN;
                else begin
                    if (b == LBL_PLAIN_TEXT) pend_valid = 0;
                    phase = PH_EXT_SUB_LEN;
                end
            end
            PH_GCE: begin
                if (pos == 0 && b != 8'd4) abort_parse(ST_FMT);
                else begin
                    if (pos == 2) saved = b;
                    if (pos == 3) begin
                        raw = {b, saved};
                        if (raw == 0) raw = cs_of(cfg_default);
                        else if (32'(raw) * 10 < 32'(cfg_min)) raw = cs_of(cfg_min);
                        pend_delay = raw;
                    end
                    if (pos == 5) begin
                        if (b != 0) abort_parse(ST_FMT);
                        else begin
                            pend_valid = 1;
                            pos = 0;
                            phase = PH_BLOCK;
                        end
                    end else pos++;
                end
            end
            PH_APP_LEN: begin
                if (count_block()) begin
                    if (b == 0) phase = PH_BLOCK;
                    else begin
                        id_flags = (b == 8'd11) ? 2'b11 : 2'b00;
                        skip = 10'(b);
                        pos = 0;
                        phase = PH_APP_ID;
                    end
                end
            end
            PH_APP_ID: begin
                if (pos < 11) begin
                    if (b != LOOP_ID_A[pos]) id_flags[0] = 0;
                    if (b != LOOP_ID_B[pos]) id_flags[1] = 0;
                end
                pos = pos + 1;
                skip = skip - 1;
                if (skip == 0) begin
                    pos = 0;
                    if (id_flags != 0) begin
                        if (loop_seen) abort_parse(ST_FMT);
                        else phase = PH_APP_VLEN;
                    end else phase = PH_EXT_SUB_LEN;
                end
            end
            PH_APP_VLEN: begin
                if (count_block()) begin
                    if (b != 8'd3) abort_parse(ST_FMT);
                    else begin
                        pos = 0;
                        phase = PH_APP_VAL;
                    end
                end
            end
            PH_APP_VAL: begin
                if (pos == 0) begin
                    if (b != 8'd1) abort_parse(ST_FMT);
                    else pos++;
                end else if (pos == 1) begin
                    saved = b;
                    pos++;
                end else begin
                    loop_val = {1'b0, b, saved};
                    pos = 0;
                    phase = PH_APP_TERM;
                end
            end
            PH_APP_TERM: begin
                if (count_block()) begin
                    if (b != 0) abort_parse(ST_FMT);
                    else begin
                        loop_seen = 1;
                        phase = PH_BLOCK;
                    end
                end
            end
            PH_EXT_SUB_LEN, PH_IMG_SUB_LEN: begin
                if (count_block()) begin
                    if (b != 0) begin
                        skip = 10'(b);
                        phase = (phase == PH_EXT_SUB_LEN) ? PH_EXT_SUB_DATA : PH_IMG_SUB_DATA;
                    end else if (phase == PH_EXT_SUB_LEN) phase = PH_BLOCK;
                    else begin
                        // image data terminator: the frame is complete
                        dl = pend_valid ? pend_delay : cs_of(cfg_default);
                        d10 = 64'(dl) * 10;
                        if (total_ms > DUR_MAX - d10) abort_parse(ST_LIM);
                        else begin
                            total_ms = total_ms + d10;
                            if (cfg_max_dur != 0 && total_ms > 64'(cfg_max_dur))
                                abort_parse(ST_LIM);
                            else begin
                                d = dl;
                                pend_valid = 0;
                                phase = PH_BLOCK;
                                r = 1;
                            end
                        end
                    end
                end
            end
            PH_EXT_SUB_DATA, PH_IMG_SUB_DATA: begin
                skip = skip - 1;
                if (skip == 0)
                    phase = (phase == PH_EXT_SUB_DATA) ? PH_EXT_SUB_LEN : PH_IMG_SUB_LEN;
            end
            PH_IMG_DESC: begin
                if (pos == 8) begin
                    saved = b;
                    pos = 0;
                    if (b[7]) begin
                        skip = color_table_bytes(b);
                        phase = PH_IMG_LTABLE;
                    end else phase = PH_IMG_LZW;
                end else pos++;
            end
            PH_IMG_LZW: begin
                if (b < 2 || b > 8) abort_parse(ST_FMT);
                else phase = PH_IMG_SUB_LEN;
            end
            default: abort_parse(ST_FMT);
        endcase
        return r;
    endfunction

    function automatic void predict_beat(input logic [7:0] b, input bit last);
        delay_result_t e;
        logic [15:0] d;
        int r;
        r = 0;
        d = 0;
        if (!waiting_last) r = parse_byte(b, last, d);
        if (last) begin
            e.kind = 1;
            e.frame_index = 0;
            e.delay_cs = 0;
            if (waiting_last) e.status = (phase == PH_FAIL_LIM) ? ST_LIM : ST_FMT;
            else e.status = (r == 2) ? ST_OK : ST_FMT;
            e.loop_count = (e.status == ST_OK) ? loop_val : LOOP_NONE;
            expected_results.push_back(e);
            clear_parser();
        end else if (r == 1) begin
            e.kind = 0;
            e.frame_index = frames;
            e.delay_cs = d;
            e.status = ST_OK;
            e.loop_count = LOOP_NONE;
            expected_results.push_back(e);
            frames = frames + 1;
        end
    endfunction

    always @(posedge aclk) begin
        delay_result_t e;
        if (!aresetn) begin
            cfg_frames = 1; cfg_max_dur = 0; cfg_default = 100; cfg_min = 20;
            cfg_max_blocks = 65536;
            clear_parser();
            expected_results.delete();
            errors = 0;
        end else begin
            // compare first: a result never belongs to the byte of the same edge
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat tdata=%h tuser=%b",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_tuser !== e.kind || m_tdata[15:0] !== e.frame_index ||
                        m_tdata[31:16] !== e.delay_cs || m_tdata[33:32] !== e.status ||
                        m_tdata[50:34] !== e.loop_count || m_tdata[55:51] !== 5'd0) begin
                        $display("%0t: mismatch expected kind=%0d idx=%0d delay=%0d st=%0d loop=%h",
                                 $time, e.kind, e.frame_index, e.delay_cs, e.status,
                                 e.loop_count);
                        $display("%0t:          actual kind=%0d idx=%0d delay=%0d st=%0d loop=%h pad=%h",
                                 $time, m_tuser, m_tdata[15:0], m_tdata[31:16],
                                 m_tdata[33:32], m_tdata[50:34], m_tdata[55:51]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_beat(s_tdata, s_tlast);
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_EXPECTED_FRAMES: cfg_frames = pwdata[15:0];
                    REG_MAX_DURATION:    cfg_max_dur = pwdata[30:0];
                    REG_DEFAULT_DELAY:   cfg_default = pwdata[19:0];
                    REG_MIN_DELAY:       cfg_min = pwdata[19:0];
                    REG_MAX_BLOCKS:      cfg_max_blocks = pwdata[19:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: verif/gif_frame_delay_extractor_tb.sv
`timescale 1ns / 1ps
// Top of the GIF frame delay extractor testbench: builds GIF byte streams,
// drives the byte and register ports and gives the verdict.
// Depends on gfde_pkg, gif_frame_delay_extractor and gfde_stream_checker.
module gif_frame_delay_extractor_tb;
    import gfde_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // [15:0] frame_index, [31:16] delay_cs, [33:32] status,
                            // [50:34] loop_count, rest zero
    logic        m_tuser;   // kind
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int outstanding;

    // bytes of the file under construction
    logic [7:0] gif_bytes[$];
    int         bytes_sent;
    bit         tx_steady;     // no gaps on the byte side while set
    bit         rx_steady;     // no stalls on the result side while set
    int         rx_hold;

    gif_frame_delay_extractor u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    gfde_stream_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .errors(errors), .outstanding(outstanding)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side backpressure: mostly short stalls, a few long ones.
    always @(posedge aclk) begin
        int roll;
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else begin
            m_tready <= 1'b1;
            roll = $urandom_range(99);
            if (!rx_steady && roll < 20) rx_hold = $urandom_range(3, 1);
            else if (!rx_steady && roll < 23) rx_hold = $urandom_range(40, 10);
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (tx_steady || roll < 70) return 0;
        if (roll < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Present one byte beat and hold it until the block takes it.
    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_file();
        tx_steady = ($urandom_range(3) == 0);
        foreach (gif_bytes[i]) send_byte(gif_bytes[i], i == gif_bytes.size() - 1);
        s_tvalid <= 1'b0;
        gif_bytes.delete();
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain all results, then allow the pipeline to settle.
    task automatic wait_drained();
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_limits(input logic [15:0] frames, input logic [30:0] dur,
                              input logic [19:0] dflt, input logic [19:0] mind,
                              input logic [19:0] blks);
        reg_write(REG_EXPECTED_FRAMES, 32'(frames));
        reg_write(REG_MAX_DURATION, 32'(dur));
        reg_write(REG_DEFAULT_DELAY, 32'(dflt));
        reg_write(REG_MIN_DELAY, 32'(mind));
        reg_write(REG_MAX_BLOCKS, 32'(blks));
    endtask

    task automatic add_random(input int n);
        repeat (n) gif_bytes.push_back(8'($urandom));
    endtask

    // Data sub-blocks and their zero terminator.
    task automatic add_subblocks(input int n, input int maxlen);
        int len;
        repeat (n) begin
            len = ($urandom_range(19) == 0) ? 255 : $urandom_range(maxlen, 1);
            gif_bytes.push_back(8'(len));
            add_random(len);
        end
        gif_bytes.push_back(8'h00);
    endtask

    // Signature, screen size, packed flags, background and aspect, then the optional global color table.
    task automatic add_header(input bit gct, input int gct_bits);
        logic [7:0] pk;
        add_random(10);
        pk = 8'($urandom);
        pk[7] = gct;
        pk[2:0] = 3'(gct_bits);
        gif_bytes.push_back(pk);
        add_random(2);
        if (gct) add_random(3 << (gct_bits + 1));
    endtask

    task automatic add_gce(input logic [15:0] delay, input bit well_formed);
        gif_bytes.push_back(GIF_EXT_INTRO);
        gif_bytes.push_back(LBL_GCE);
        gif_bytes.push_back(well_formed ? 8'd4 : 8'($urandom_range(255, 5)));
        add_random(1);
        gif_bytes.push_back(delay[7:0]);
        gif_bytes.push_back(delay[15:8]);
        add_random(1);
        gif_bytes.push_back(well_formed ? 8'h00 : 8'($urandom_range(255, 1)));
    endtask

    // Application extension: 0 first looping id, 1 second, 2 near miss,
    // 3 odd id length, 4 empty id.
    task automatic add_app(input int flavor, input logic [15:0] loops);
        int slip;
        gif_bytes.push_back(GIF_EXT_INTRO);
        gif_bytes.push_back(LBL_APP);
        if (flavor == 4) begin
            gif_bytes.push_back(8'h00);
            return;
        end
        if (flavor == 3) begin
            gif_bytes.push_back(8'($urandom_range(10, 1)));
            add_random(gif_bytes[$]);
            add_subblocks($urandom_range(2), 6);
            return;
        end
        gif_bytes.push_back(8'd11);
        slip = $urandom_range(10);
        for (int i = 0; i < 11; i++) begin
            if (flavor == 1) gif_bytes.push_back(LOOP_ID_B[i]);
            else if (flavor == 2 && i == slip) gif_bytes.push_back(LOOP_ID_A[i] ^ 8'h20);
            else gif_bytes.push_back(LOOP_ID_A[i]);
        end
        if (flavor == 2) begin
            add_subblocks($urandom_range(2), 6);
            return;
        end
        gif_bytes.push_back(8'd3);
        gif_bytes.push_back(8'd1);
        gif_bytes.push_back(loops[7:0]);
        gif_bytes.push_back(loops[15:8]);
        gif_bytes.push_back(8'h00);
    endtask

    task automatic add_ext(input logic [7:0] label);
        gif_bytes.push_back(GIF_EXT_INTRO);
        gif_bytes.push_back(label);
        add_subblocks($urandom_range(2), 12);
    endtask

    task automatic add_image(input bit lct, input int lct_bits, input logic [7:0] lzw,
                             input int nsub);
        logic [7:0] pk;
        gif_bytes.push_back(GIF_IMG_INTRO);
        add_random(8);
        pk = 8'($urandom);
        pk[7] = lct;
        pk[2:0] = 3'(lct_bits);
        gif_bytes.push_back(pk);
        if (lct) add_random(3 << (lct_bits + 1));
        gif_bytes.push_back(lzw);
        add_subblocks(nsub, 8);
    endtask

    function automatic logic [15:0] pick_delay();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'($urandom_range(3, 1));
            2: return 16'($urandom);
            default: return 16'($urandom_range(60, 2));
        endcase
    endfunction

    // Mostly well-formed files with random content; some damaged or pure noise.
    task automatic build_random_file(input int nframes);
        int cut;
        if ($urandom_range(11) == 0) begin
            add_random($urandom_range(30, 1));
            return;
        end
        add_header($urandom_range(3) == 0, $urandom_range(1));
        if ($urandom_range(2) == 0) add_app($urandom_range(4), 16'($urandom));
        for (int f = 0; f < nframes; f++) begin
            if ($urandom_range(5) == 0) add_ext(8'($urandom));
            if ($urandom_range(7) == 0) add_ext(LBL_PLAIN_TEXT);
            if ($urandom_range(3) != 0) add_gce(pick_delay(), $urandom_range(19) != 0);
            if ($urandom_range(9) == 0) add_app($urandom_range(1), 16'($urandom));
            if ($urandom_range(7) == 0) add_ext(LBL_PLAIN_TEXT);
            add_image($urandom_range(4) == 0, $urandom_range(1),
                      ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(8, 2)),
                      $urandom_range(3));
        end
        if ($urandom_range(9) == 0) add_gce(pick_delay(), 1'b1);
        gif_bytes.push_back(GIF_TRAILER);
        case ($urandom_range(9))
            0: begin
                cut = $urandom_range(gif_bytes.size() - 1, 1);
                while (gif_bytes.size() > cut) void'(gif_bytes.pop_back());
            end
            1: gif_bytes[$urandom_range(gif_bytes.size() - 1)] = 8'($urandom);
            2: add_random($urandom_range(3, 1));
            default: ;
        endcase
    endtask

    task automatic run_random_phase(input int budget, input logic [15:0] frames);
        int goal;
        int n;
        goal = bytes_sent + budget;
        while (bytes_sent < goal) begin
            rx_steady = ($urandom_range(4) == 0);
            if (frames <= 4 && $urandom_range(9) != 0) n = frames;
            else n = $urandom_range(4, 1);
            build_random_file(n);
            send_file();
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'h00;
        s_tlast <= 1'b0;
        m_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 5'd0;
        pwdata <= 32'd0;
        bytes_sent = 0;
        tx_steady = 0;
        rx_steady = 0;
        rx_hold = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed files under two expected frames.
        set_limits(16'd2, 31'd0, 20'd100, 20'd20, 20'd65536);
        // zero delay takes the default, a tiny one is raised to the minimum,
        // the second looping id sets the loop count, plain text drops a delay
        add_header(1'b0, 0);
        add_app(1, 16'hFFFF);
        add_gce(16'd0, 1'b1);
        add_image(1'b0, 0, 8'd2, 1);
        add_gce(16'd1, 1'b1);
        add_ext(LBL_PLAIN_TEXT);
        add_image(1'b1, 0, 8'd8, 0);
        gif_bytes.push_back(GIF_TRAILER);
        send_file();
        // unknown introducer
        add_header(1'b0, 0);
        gif_bytes.push_back(8'h00);
        send_file();
        // trailer before the end, then a second looping extension
        add_header(1'b0, 0);
        gif_bytes.push_back(GIF_TRAILER);
        gif_bytes.push_back(GIF_TRAILER);
        send_file();
        add_header(1'b0, 0);
        add_app(0, 16'h0000);
        add_app(0, 16'h1234);
        gif_bytes.push_back(GIF_TRAILER);
        send_file();
        // bad code size and a dangling delay at the trailer
        add_header(1'b0, 0);
        add_image(1'b0, 0, 8'd1, 1);
        gif_bytes.push_back(GIF_TRAILER);
        send_file();
        add_header(1'b0, 0);
        add_image(1'b0, 0, 8'd2, 1);
        add_image(1'b0, 0, 8'd2, 1);
        add_gce(16'd5, 1'b1);
        gif_bytes.push_back(GIF_TRAILER);
        send_file();

        // Hold the byte side until everything predicted has been seen.
        wait_drained();
        run_random_phase(250, 16'd2);
        wait_drained();

        // Default of 10 ms, zero minimum, largest block limit, one full global table.
        set_limits(16'd1, 31'd0, 20'd10, 20'd0, 20'd1048575);
        add_header(1'b1, 7);
        add_image(1'b0, 0, 8'd4, 1);
        gif_bytes.push_back(GIF_TRAILER);
        send_file();
        run_random_phase(200, 16'd1);
        wait_drained();

        // Delays at the 16-bit top and the widest duration limit.
        set_limits(16'd3, 31'h7FFFFFFF, 20'd655350, 20'd655350, 20'd1048575);
        run_random_phase(300, 16'd3);
        wait_drained();

        // Tight duration limit: totals overrun after a frame or two.
        set_limits(16'($urandom_range(4, 1)), 31'($urandom_range(600, 1)),
                   20'($urandom_range(400, 10)), 20'($urandom_range(300)), 20'd1048575);
        run_random_phase(250, u_checker.cfg_frames);
        wait_drained();

        // One block allowed: the second counted block fails.
        set_limits(16'd1, 31'd0, 20'd100, 20'd20, 20'd1);
        run_random_phase(120, 16'd1);
        wait_drained();

        // Small block limits reached partway through a file.
        set_limits(16'd2, 31'd0, 20'($urandom_range(655350, 10)),
                   20'($urandom_range(655350)), 20'($urandom_range(25, 4)));
        run_random_phase(250, 16'd2);
        wait_drained();

        // Most frames expected: every trailer is early.
        set_limits(16'd65535, 31'($urandom), 20'($urandom_range(655350, 10)),
                   20'($urandom_range(1000)), 20'd65536);
        run_random_phase(150, 16'd65535);
        wait_drained();

        // Random mid-range settings.
        repeat (2) begin
            set_limits(16'($urandom_range(4, 1)), 31'($urandom_range(200000)),
                       20'($urandom_range(2000, 10)), 20'($urandom_range(500)),
                       20'($urandom_range(200, 20)));
            run_random_phase(250, u_checker.cfg_frames);
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
